>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the voice allocator.
// No dependencies; included by modules that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational check sampled every clock, masked during reset.
`define ASSERT_NOW(lbl, clk, rstn, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) else $error(msg);

// Temporal property sampled every clock, masked during reset.
`define ASSERT_AT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

`endif

>>> hw/rtl/pva_pkg.sv
// Package of the priority voice allocator: field widths, op codes, defaults.
// No dependencies.
package pva_pkg;

  localparam int OP_W      = 3;
  localparam int SLOT_W    = 6;
  localparam int PRIO_W    = 5;
  localparam int CNT_OUT_W = 7;

  localparam int NUM_VOICES_DEF = 64;
  localparam int STAMP_BITS_DEF = 32;

  localparam logic [OP_W-1:0] OP_ACQUIRE   = 3'd0;
  localparam logic [OP_W-1:0] OP_FREE      = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_PRIO  = 3'd2;
  localparam logic [OP_W-1:0] OP_SET_STATE = 3'd3;
  localparam logic [OP_W-1:0] OP_INIT      = 3'd4;

endpackage

>>> hw/rtl/pva_in_if.sv
// Request channel of the voice allocator.
// Depends on pva_pkg.
interface pva_in_if;
  import pva_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [SLOT_W-1:0] slot;
  logic [PRIO_W-1:0] priority_req;
  logic              playing;

  modport source (output valid, op, slot, priority_req, playing, input ready);
  modport sink   (input valid, op, slot, priority_req, playing, output ready);
endinterface

>>> hw/rtl/pva_out_if.sv
// Result channel of the voice allocator.
// Depends on pva_pkg.
interface pva_out_if;
  import pva_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 granted;
  logic [SLOT_W-1:0]    granted_slot;
  logic                 stole;
  logic                 depop;
  logic [CNT_OUT_W-1:0] in_use_count;

  modport source (output valid, granted, granted_slot, stole, depop, in_use_count,
                  input ready);
  modport sink   (input valid, granted, granted_slot, stole, depop, in_use_count,
                  output ready);
endinterface

>>> hw/rtl/pva_cfg_if.sv
// Configuration write channel of the voice allocator (voices_enabled).
// No dependencies.
interface pva_cfg_if;
  logic valid;
  logic ready;
  logic data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

>>> hw/rtl/priority_voice_allocator_top.sv
// Priority voice allocator: voice pool with lowest-free acquire and lowest-priority, oldest-victim steal.
// Depends on pva_pkg, pva_in_if, pva_out_if, pva_cfg_if and assert_macros.svh.
//
//  channel | dir | payload                                          | transaction
//  in_ch   | in  | op, slot, priority_req, playing                  | valid & ready
//  out_ch  | out | granted, granted_slot, stole, depop, in_use_count | valid & ready
//  cfg_ch  | in  | data = voices_enabled                            | valid & ready
//
// One request in flight. Acquire walks the voice memory one slot per cycle: it
// ends at the first free slot, else after a steal search over every slot.
// Free, set priority and set state take a read and a write-back, but finish
// at once with a slot out of range, as init, unknown ops and disabled acquires
// do. S_DONE then loads the output register, after which the next request is taken.
// Per-slot valid bits cleared by reset and init stand for a zeroed memory.
// A stalled output holds the result; a new request waits until it is taken.
`include "assert_macros.svh"

module priority_voice_allocator_top #(
  parameter int NUM_VOICES = pva_pkg::NUM_VOICES_DEF,
  parameter int STAMP_BITS = pva_pkg::STAMP_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  pva_in_if.sink    in_ch,
  pva_out_if.source out_ch,
  pva_cfg_if.sink   cfg_ch
);
  import pva_pkg::*;

  localparam int IDX_W = $clog2(NUM_VOICES);
  localparam int CNT_W = $clog2(NUM_VOICES + 1);
  localparam int ENT_W = PRIO_W + 1 + STAMP_BITS;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_VOICES - 1);

  typedef enum logic [2:0] {
    S_IDLE, S_RMW_RD, S_RMW_WR, S_SCAN, S_DONE
  } state_t;

  state_t                state_r, state_nxt;
  logic                  enable_r, enable_nxt;
  logic                  pool_ready_r, pool_ready_nxt;
  logic [NUM_VOICES-1:0] valid_r, valid_nxt;
  logic [NUM_VOICES-1:0] in_use_r, in_use_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [STAMP_BITS-1:0] stamp_ctr_r, stamp_ctr_nxt;

  logic [OP_W-1:0]       op_r, op_nxt;
  logic [IDX_W-1:0]      slot_r, slot_nxt;
  logic [PRIO_W-1:0]     prio_r, prio_nxt;
  logic                  play_r, play_nxt;

  logic [IDX_W-1:0]      scan_idx_r, scan_idx_nxt;
  logic                  issue_done_r, issue_done_nxt;
  logic                  scan_live_r, scan_live_nxt;
  logic [IDX_W-1:0]      scan_q_r, scan_q_nxt;

  logic                  best_vld_r, best_vld_nxt;
  logic [IDX_W-1:0]      best_idx_r, best_idx_nxt;
  logic [PRIO_W-1:0]     best_prio_r, best_prio_nxt;
  logic [STAMP_BITS-1:0] best_stamp_r, best_stamp_nxt;
  logic                  best_play_r, best_play_nxt;

  logic                  res_granted_r, res_granted_nxt;
  logic [SLOT_W-1:0]     res_slot_r, res_slot_nxt;
  logic                  res_stole_r, res_stole_nxt;
  logic                  res_depop_r, res_depop_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic                  out_granted_r, out_granted_nxt;
  logic [SLOT_W-1:0]     out_slot_r, out_slot_nxt;
  logic                  out_stole_r, out_stole_nxt;
  logic                  out_depop_r, out_depop_nxt;
  logic [CNT_OUT_W-1:0]  out_cnt_r, out_cnt_nxt;

  // Voice memory: {priority, playing, stamp}
  logic [ENT_W-1:0]      mem [NUM_VOICES];
  logic [ENT_W-1:0]      rdata_r;
  logic                  rvld_r;
  logic [IDX_W-1:0]      rd_addr;
  logic                  wr_en;
  logic [IDX_W-1:0]      wr_addr;
  logic [ENT_W-1:0]      wr_data;

  logic [PRIO_W-1:0]     e_prio;
  logic                  e_play;
  logic [STAMP_BITS-1:0] e_stamp;

  logic                  in_fire;
  logic                  slot_ok;
  logic [IDX_W-1:0]      slot_idx;
  logic [SLOT_W+IDX_W-1:0]     slot_ext;
  logic [SLOT_W+IDX_W-1:0]     pick_ext;
  logic [CNT_OUT_W+CNT_W-1:0]  cnt_ext;

  logic                  grant_go;
  logic                  grant_steal;
  logic                  grant_depop;
  logic [IDX_W-1:0]      grant_idx;
  logic [STAMP_BITS-1:0] stamp_inc;

  assign in_fire      = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign slot_ext = {{IDX_W{1'b0}}, in_ch.slot};
  assign slot_idx = slot_ext[IDX_W-1:0];
  assign slot_ok  = (int'(in_ch.slot) < NUM_VOICES);
  assign pick_ext = {{SLOT_W{1'b0}}, grant_idx};
  assign cnt_ext  = {{CNT_OUT_W{1'b0}}, cnt_r};
  assign stamp_inc = stamp_ctr_r + 1'b1;

  assign rd_addr = (state_r == S_RMW_RD) ? slot_r : scan_idx_r;

  // Entry never written since the last clear reads as zero
  assign {e_prio, e_play, e_stamp} = rvld_r ? rdata_r : '0;

  assign out_ch.valid        = out_valid_r;
  assign out_ch.granted      = out_granted_r;
  assign out_ch.granted_slot = out_slot_r;
  assign out_ch.stole        = out_stole_r;
  assign out_ch.depop        = out_depop_r;
  assign out_ch.in_use_count = out_cnt_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rdata_r <= mem[rd_addr];
    rvld_r  <= valid_r[rd_addr];
  end

  always_comb begin
    state_nxt      = state_r;
    enable_nxt     = enable_r;
    pool_ready_nxt = pool_ready_r;
    valid_nxt      = valid_r;
    in_use_nxt     = in_use_r;
    cnt_nxt        = cnt_r;
    stamp_ctr_nxt  = stamp_ctr_r;
    op_nxt         = op_r;
    slot_nxt       = slot_r;
    prio_nxt       = prio_r;
    play_nxt       = play_r;
    scan_idx_nxt   = scan_idx_r;
    issue_done_nxt = issue_done_r;
    scan_live_nxt  = scan_live_r;
    scan_q_nxt     = scan_q_r;
    best_vld_nxt   = best_vld_r;
    best_idx_nxt   = best_idx_r;
    best_prio_nxt  = best_prio_r;
    best_stamp_nxt = best_stamp_r;
    best_play_nxt  = best_play_r;
    res_granted_nxt = res_granted_r;
    res_slot_nxt    = res_slot_r;
    res_stole_nxt   = res_stole_r;
    res_depop_nxt   = res_depop_r;
    out_valid_nxt   = out_valid_r;
    out_granted_nxt = out_granted_r;
    out_slot_nxt    = out_slot_r;
    out_stole_nxt   = out_stole_r;
    out_depop_nxt   = out_depop_r;
    out_cnt_nxt     = out_cnt_r;
    wr_en       = 1'b0;
    wr_addr     = slot_r;
    wr_data     = '0;
    grant_go    = 1'b0;
    grant_steal = 1'b0;
    grant_depop = 1'b0;
    grant_idx   = scan_idx_r;

    if (cfg_ch.valid) begin
      enable_nxt = cfg_ch.data;
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          op_nxt   = in_ch.op;
          slot_nxt = slot_idx;
          prio_nxt = in_ch.priority_req;
          play_nxt = in_ch.playing;
          res_granted_nxt = 1'b0;
          res_slot_nxt    = '0;
          res_stole_nxt   = 1'b0;
          res_depop_nxt   = 1'b0;
          state_nxt       = S_DONE;
          unique case (in_ch.op)
            OP_ACQUIRE: begin
              if (enable_r) begin
                if (!pool_ready_r) begin
                  valid_nxt      = '0;
                  in_use_nxt     = '0;
                  cnt_nxt        = '0;
                  stamp_ctr_nxt  = '0;
                  pool_ready_nxt = 1'b1;
                end
                scan_idx_nxt   = '0;
                issue_done_nxt = 1'b0;
                scan_live_nxt  = 1'b0;
                best_vld_nxt   = 1'b0;
                state_nxt      = S_SCAN;
              end
            end
            OP_FREE, OP_SET_PRIO, OP_SET_STATE: begin
              if (slot_ok) begin
                state_nxt = S_RMW_RD;
              end
            end
            OP_INIT: begin
              valid_nxt      = '0;
              in_use_nxt     = '0;
              cnt_nxt        = '0;
              stamp_ctr_nxt  = '0;
              pool_ready_nxt = 1'b1;
            end
            default: ;
          endcase
        end
      end

      S_RMW_RD: begin
        state_nxt = S_RMW_WR;
      end

      S_RMW_WR: begin
        wr_en              = 1'b1;
        wr_addr            = slot_r;
        valid_nxt[slot_r]  = 1'b1;
        state_nxt          = S_DONE;
        unique case (op_r)
          OP_FREE: begin
            wr_data       = {e_prio, 1'b0, e_stamp};
            res_depop_nxt = e_play;
            if (in_use_r[slot_r]) begin
              in_use_nxt[slot_r] = 1'b0;
              cnt_nxt            = cnt_r - 1'b1;
            end
          end
          OP_SET_PRIO: begin
            wr_data = {prio_r, e_play, e_stamp};
          end
          default: begin
            wr_data       = {e_prio, play_r, e_stamp};
            res_depop_nxt = !play_r;
          end
        endcase
      end

      S_SCAN: begin
        // Victim compare on the entry read last cycle
        if (scan_live_r && (e_prio < prio_r)) begin
          if (!best_vld_r || (e_prio < best_prio_r) ||
              ((e_prio == best_prio_r) && (e_stamp < best_stamp_r))) begin
            best_vld_nxt   = 1'b1;
            best_idx_nxt   = scan_q_r;
            best_prio_nxt  = e_prio;
            best_stamp_nxt = e_stamp;
            best_play_nxt  = e_play;
          end
        end
        scan_live_nxt = 1'b0;
        if (!issue_done_r) begin
          if (!in_use_r[scan_idx_r]) begin
            grant_go  = 1'b1;
            grant_idx = scan_idx_r;
          end else begin
            scan_live_nxt = 1'b1;
            scan_q_nxt    = scan_idx_r;
            if (scan_idx_r == LAST_IDX) begin
              issue_done_nxt = 1'b1;
            end else begin
              scan_idx_nxt = scan_idx_r + 1'b1;
            end
          end
        end else begin
          state_nxt = S_DONE;
          if (best_vld_nxt) begin
            grant_go    = 1'b1;
            grant_steal = 1'b1;
            grant_depop = best_play_nxt;
            grant_idx   = best_idx_nxt;
          end
        end
      end

      S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt   = 1'b1;
          out_granted_nxt = res_granted_r;
          out_slot_nxt    = res_slot_r;
          out_stole_nxt   = res_stole_r;
          out_depop_nxt   = res_depop_r;
          out_cnt_nxt     = cnt_ext[CNT_OUT_W-1:0];
          state_nxt       = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase

    if (grant_go) begin
      stamp_ctr_nxt         = stamp_inc;
      wr_en                 = 1'b1;
      wr_addr               = grant_idx;
      wr_data               = {prio_r, 1'b0, stamp_inc};
      valid_nxt[grant_idx]  = 1'b1;
      in_use_nxt[grant_idx] = 1'b1;
      if (!grant_steal) begin
        cnt_nxt = cnt_r + 1'b1;
      end
      res_granted_nxt = 1'b1;
      res_slot_nxt    = pick_ext[SLOT_W-1:0];
      res_stole_nxt   = grant_steal;
      res_depop_nxt   = grant_depop;
      state_nxt       = S_DONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      enable_r     <= 1'b0;
      pool_ready_r <= 1'b0;
      valid_r      <= '0;
      in_use_r     <= '0;
      cnt_r        <= '0;
      stamp_ctr_r  <= '0;
      issue_done_r <= 1'b0;
      scan_live_r  <= 1'b0;
      best_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      enable_r     <= enable_nxt;
      pool_ready_r <= pool_ready_nxt;
      valid_r      <= valid_nxt;
      in_use_r     <= in_use_nxt;
      cnt_r        <= cnt_nxt;
      stamp_ctr_r  <= stamp_ctr_nxt;
      issue_done_r <= issue_done_nxt;
      scan_live_r  <= scan_live_nxt;
      best_vld_r   <= best_vld_nxt;
      out_valid_r  <= out_valid_nxt;
      op_r         <= op_nxt;
      slot_r       <= slot_nxt;
      prio_r       <= prio_nxt;
      play_r       <= play_nxt;
      scan_idx_r   <= scan_idx_nxt;
      scan_q_r     <= scan_q_nxt;
      best_idx_r   <= best_idx_nxt;
      best_prio_r  <= best_prio_nxt;
      best_stamp_r <= best_stamp_nxt;
      best_play_r  <= best_play_nxt;
      res_granted_r <= res_granted_nxt;
      res_slot_r    <= res_slot_nxt;
      res_stole_r   <= res_stole_nxt;
      res_depop_r   <= res_depop_nxt;
      out_granted_r <= out_granted_nxt;
      out_slot_r    <= out_slot_nxt;
      out_stole_r   <= out_stole_nxt;
      out_depop_r   <= out_depop_nxt;
      out_cnt_r     <= out_cnt_nxt;
    end
  end

  `ASSERT_NOW(a_cnt_match, clk, rst_n, $countones(in_use_r) == int'(cnt_r), "in-use count out of sync")
  `ASSERT_NOW(a_fail_clean, clk, rst_n, !out_valid_r || out_granted_r || ((out_slot_r == '0) && !out_stole_r), "failed acquire reports slot or steal")
  `ASSERT_AT(a_steal_full, clk, rst_n, (grant_go && grant_steal) |-> (&in_use_r), "steal with a free slot left")
  `ASSERT_AT(a_stamp_step, clk, rst_n, grant_go |=> (stamp_ctr_r == STAMP_BITS'($past(stamp_ctr_r) + 1'b1)), "stamp counter did not advance")

endmodule

>>> verif/tb_priority_voice_allocator_top.sv
// Testbench for priority_voice_allocator_top: directed and random request traffic against a voice pool
// predictor held in a small scoreboard class. Depends on pva_pkg and the three channel
// interfaces (pva_in_if, pva_out_if, pva_cfg_if) from the RTL.
`timescale 1ns / 100ps

module tb_priority_voice_allocator_top;
  import pva_pkg::*;

  localparam int NV           = NUM_VOICES_DEF;
  localparam int ITEM_TARGET  = 1800;
  localparam int MAX_GAP      = 13;
  localparam int HOLD_CYCLES  = 400;
  localparam int IDLE_LIMIT   = 4000;
  localparam int TAIL_CYCLES  = 2 * NV + 8;
  localparam int MAX_REPORTS  = 10;
  localparam logic [OP_W-1:0] OP_LAST_UNUSED = 3'd7;

  typedef struct packed {
    logic                 granted;
    logic [SLOT_W-1:0]    granted_slot;
    logic                 stole;
    logic                 depop;
    logic [CNT_OUT_W-1:0] in_use_count;
  } alloc_result_t;

  class voice_pool_scoreboard;
    bit                voices_on;
    bit                pool_ready;
    bit                in_use [NV];
    logic [PRIO_W-1:0] voice_prio [NV];
    bit                voice_play [NV];
    logic [31:0]       stamp [NV];
    logic [31:0]       stamp_counter;
    alloc_result_t     expected [$];
    int                errors;
    int                results_seen;
    int                grants;
    int                steals;
    int                depops;

    function new();
      voices_on = 1'b0;
      clear_pool();
      pool_ready = 1'b0;
    endfunction

    function void clear_pool();
      for (int i = 0; i < NV; i++) begin
        in_use[i]     = 1'b0;
        voice_prio[i] = '0;
        voice_play[i] = 1'b0;
        stamp[i]      = '0;
      end
      stamp_counter = '0;
      pool_ready    = 1'b1;
    endfunction

    function int pending();
      return expected.size();
    endfunction

    function void note_request(logic [OP_W-1:0] op, logic [SLOT_W-1:0] slot,
                               logic [PRIO_W-1:0] prq, logic play);
      alloc_result_t r;
      int            pick;
      bit            steal;
      int            n;
      r     = '0;
      pick  = NV;
      steal = 1'b0;
      n     = 0;
      case (op)
        OP_ACQUIRE: begin
          if (voices_on) begin
            if (!pool_ready) clear_pool();
            for (int i = 0; i < NV; i++)
              if (!in_use[i] && pick == NV) pick = i;
            if (pick == NV) begin
              steal = 1'b1;
              for (int i = 0; i < NV; i++) begin
                if (voice_prio[i] < prq) begin
                  if (pick == NV || voice_prio[i] < voice_prio[pick] ||
                      (voice_prio[i] == voice_prio[pick] && stamp[i] < stamp[pick]))
                    pick = i;
                end
              end
            end
            if (pick < NV) begin
              if (steal) begin
                r.stole = 1'b1;
                r.depop = voice_play[pick];
              end
              stamp_counter    = stamp_counter + 1;
              in_use[pick]     = 1'b1;
              stamp[pick]      = stamp_counter;
              voice_prio[pick] = prq;
              voice_play[pick] = 1'b0;
              r.granted        = 1'b1;
              r.granted_slot   = pick[SLOT_W-1:0];
            end
          end
        end
        OP_FREE: begin
          r.depop          = voice_play[slot];
          voice_play[slot] = 1'b0;
          in_use[slot]     = 1'b0;
        end
        OP_SET_PRIO: voice_prio[slot] = prq;
        OP_SET_STATE: begin
          voice_play[slot] = play;
          r.depop          = !play;
        end
        OP_INIT: clear_pool();
        default: ;
      endcase
      for (int i = 0; i < NV; i++) n += in_use[i];
      r.in_use_count = n[CNT_OUT_W-1:0];
      grants += r.granted;
      steals += r.stole;
      depops += r.depop;
      expected.push_back(r);
    endfunction

    function void check_result(alloc_result_t act);
      alloc_result_t exp_r;
      results_seen++;
      if (expected.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: result with nothing expected: g=%0d slot=%0d st=%0d dp=%0d cnt=%0d",
                   act.granted, act.granted_slot, act.stole, act.depop, act.in_use_count);
        return;
      end
      exp_r = expected.pop_front();
      if (act.granted !== exp_r.granted || act.granted_slot !== exp_r.granted_slot ||
          act.stole !== exp_r.stole || act.depop !== exp_r.depop ||
          act.in_use_count !== exp_r.in_use_count) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("ERROR: result %0d exp g=%0d slot=%0d st=%0d dp=%0d cnt=%0d, got g=%0d slot=%0d st=%0d dp=%0d cnt=%0d",
                   results_seen, exp_r.granted, exp_r.granted_slot, exp_r.stole,
                   exp_r.depop, exp_r.in_use_count, act.granted, act.granted_slot,
                   act.stole, act.depop, act.in_use_count);
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;

  pva_in_if  in_ch ();
  pva_out_if out_ch ();
  pva_cfg_if cfg_ch ();

  priority_voice_allocator_top dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  voice_pool_scoreboard sb = new();

  bit no_idle;
  bit long_hold_req;
  int items_sent;
  int cfg_writes;
  int idle_cycles;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  task automatic send_req(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                          input logic [PRIO_W-1:0] prq, input logic play);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid        <= 1'b1;
    in_ch.op           <= op;
    in_ch.slot         <= slot;
    in_ch.priority_req <= prq;
    in_ch.playing      <= play;
    do @(posedge clk); while (!in_ch.ready);
    sb.note_request(op, slot, prq, play);
    items_sent++;
  endtask

  // wait until every outstanding transaction has returned
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_cfg(input logic value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    sb.voices_on = value;
    cfg_writes++;
    @(posedge clk);
  endtask

  // result side
  initial begin
    int            gap;
    alloc_result_t act;
    out_ch.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = no_idle ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      act.granted      = out_ch.granted;
      act.granted_slot = out_ch.granted_slot;
      act.stole        = out_ch.stole;
      act.depop        = out_ch.depop;
      act.in_use_count = out_ch.in_use_count;
      sb.check_result(act);
    end
  end

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("ERROR: no transaction for %0d cycles", IDLE_LIMIT);
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int          blk;
    int          n;
    int          r;
    logic        en;
    idle_cycles        = 0;
    in_ch.valid        = 1'b0;
    in_ch.op           = OP_ACQUIRE;
    in_ch.slot         = '0;
    in_ch.priority_req = '0;
    in_ch.playing      = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.data        = 1'b0;
    rst_n              = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: pool never initialized, voices disabled
    write_cfg(1'b0);
    send_req(OP_ACQUIRE, 6'd0, 5'd31, 1'b1);
    send_req(OP_SET_STATE, 6'd5, 5'd0, 1'b1);
    send_req(OP_FREE, 6'd5, 5'd0, 1'b0);
    send_req(OP_SET_STATE, 6'd7, 5'd0, 1'b1);
    send_req(OP_SET_PRIO, 6'd3, 5'd31, 1'b0);
    send_req(OP_LAST_UNUSED, 6'd63, 5'd31, 1'b1);
    drain();
    write_cfg(1'b1);
    // first acquire clears the stale pool
    send_req(OP_ACQUIRE, 6'd63, 5'd0, 1'b0);
    send_req(OP_FREE, 6'd7, 5'd0, 1'b0);
    send_req(OP_SET_STATE, 6'd0, 5'd0, 1'b0);
    send_req(OP_SET_STATE, 6'd0, 5'd0, 1'b1);
    send_req(OP_ACQUIRE, 6'd0, 5'd31, 1'b1);
    send_req(OP_FREE, 6'd0, 5'd0, 1'b0);
    send_req(OP_INIT + 3'd1, 6'd21, 5'd10, 1'b0);
    send_req(OP_INIT + 3'd2, 6'd42, 5'd21, 1'b1);
    send_req(OP_INIT, 6'd0, 5'd0, 1'b0);
    send_req(OP_SET_PRIO, 6'd63, 5'd0, 1'b0);
    send_req(OP_SET_STATE, 6'd63, 5'd0, 1'b1);
    send_req(OP_FREE, 6'd63, 5'd0, 1'b0);

    blk = 0;
    while (items_sent < ITEM_TARGET) begin
      if (blk == 2) long_hold_req = 1'b1;
      if (blk > 0 && (blk % 3 == 0)) begin
        drain();
        en = (blk == 6) ? 1'b0 : (blk == 9) ? 1'b1 : ($urandom_range(0, 4) != 0);
        write_cfg(en);
      end
      no_idle = ($urandom_range(0, 4) == 0);
      if (!sb.voices_on || $urandom_range(0, 4) == 0) begin
        repeat (25)
          send_req(OP_W'($urandom_range(0, OP_LAST_UNUSED)),
                   SLOT_W'($urandom_range(0, NV - 1)),
                   PRIO_W'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
      end else begin
        if ($urandom_range(0, 3) != 0)
          send_req(OP_INIT, SLOT_W'($urandom), PRIO_W'($urandom), 1'($urandom));
        // fill the pool, then churn it with steals, frees and updates
        n = NV + $urandom_range(0, 8);
        repeat (n) begin
          r = $urandom_range(0, 9);
          if (r == 0)
            send_req(OP_SET_STATE, SLOT_W'($urandom_range(0, NV - 1)),
                     PRIO_W'($urandom), 1'($urandom));
          else if (r == 1)
            send_req(OP_SET_PRIO, SLOT_W'($urandom_range(0, NV - 1)),
                     PRIO_W'($urandom_range(0, 31)), 1'($urandom));
          else
            send_req(OP_ACQUIRE, SLOT_W'($urandom), PRIO_W'($urandom_range(0, 20)),
                     1'($urandom));
        end
        repeat (60) begin
          r = $urandom_range(0, 99);
          if (r < 45)
            send_req(OP_ACQUIRE, SLOT_W'($urandom), PRIO_W'($urandom_range(0, 31)),
                     1'($urandom));
          else if (r < 62)
            send_req(OP_FREE, SLOT_W'($urandom_range(0, NV - 1)),
                     PRIO_W'($urandom), 1'($urandom));
          else if (r < 78)
            send_req(OP_SET_STATE, SLOT_W'($urandom_range(0, NV - 1)),
                     PRIO_W'($urandom), 1'($urandom));
          else if (r < 92)
            send_req(OP_SET_PRIO, SLOT_W'($urandom_range(0, NV - 1)),
                     PRIO_W'($urandom_range(0, 31)), 1'($urandom));
          else if (r < 94)
            send_req(OP_INIT, SLOT_W'($urandom), PRIO_W'($urandom), 1'($urandom));
          else
            send_req(OP_W'($urandom_range(OP_INIT + 1, OP_LAST_UNUSED)),
                     SLOT_W'($urandom), PRIO_W'($urandom), 1'($urandom));
        end
      end
      blk++;
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0) begin
      sb.errors++;
      $display("ERROR: %0d expected results never arrived", sb.pending());
    end
    $display("Ran %0d requests in %0d phases with %0d config writes; %0d results checked.",
             items_sent, blk, cfg_writes, sb.results_seen);
    $display("Grants %0d, steals %0d, depops %0d, mismatches %0d.",
             sb.grants, sb.steals, sb.depops, sb.errors);
    if (sb.errors == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/pva_pkg.sv
hw/rtl/pva_in_if.sv
hw/rtl/pva_out_if.sv
hw/rtl/pva_cfg_if.sv
hw/rtl/priority_voice_allocator_top.sv
verif/tb_priority_voice_allocator_top.sv
